>>> sv/rpt_pkg.sv
// ----------------------------------------------------------------------------
// Rigid pose transform package
// Shared types, register indexes and pipeline depth constants.
// ----------------------------------------------------------------------------
package rpt_pkg;

  // Default fraction bits of the quaternion fixed-point format.
  localparam int QUAT_FRAC_BITS_DEF = 30;

  // Register stages of the position datapath.
  localparam int POS_STAGES = 6;

  // Register stages in front of the square root in the orientation datapath.
  localparam int NORM_FRONT_STAGES = 7;

  // One result bit of the 64-bit square root per stage.
  localparam int SQRT_STAGES = 32;

  typedef enum logic [2:0] {
    REG_ROT_W_X  = 3'd0,
    REG_ROT_Y_Z  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_CENTER_Z = 3'd4,
    REG_SHIFT_X  = 3'd5,
    REG_SHIFT_Y  = 3'd6,
    REG_SHIFT_Z  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  typedef struct packed {
    quat_t rot;
    vec3_t center;
    vec3_t shift;
  } pose_cfg_t;

endpackage

>>> sv/rigid_pose_transform.sv
// ----------------------------------------------------------------------------
// Rigid pose transform
// Moves an object pose by a configured rotation about a center plus a
// translation, and rotates and renormalizes its orientation quaternion.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Beat contents
//   -------  -------------------  ---------------------------------------------
//   in       in_valid / in_stall  position (Q16.16) and orientation (Q2.30)
//   out      out_valid/out_stall  moved position, orientation, two flags
//   cfg      cfg_we               register index and 64-bit write data
//
// One beat is accepted per cycle while in_stall is low. The depth from input to
// output is set by the 32-stage square root of the quaternion norm and the
// QUAT_FRAC_BITS + 1 stage dividers that follow it. Reset is synchronous and
// active low; it clears the valid bits and loads the identity rotation and
// zero center and shift. All stages advance together; when the output beat is
// held by out_stall the whole pipeline holds, so no beat is dropped or repeated.
//
module rigid_pose_transform
  import rpt_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_ori_w,
  input  logic signed [31:0] in_ori_x,
  input  logic signed [31:0] in_ori_y,
  input  logic signed [31:0] in_ori_z,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_ori_w,
  output logic signed [31:0] out_ori_x,
  output logic signed [31:0] out_ori_y,
  output logic signed [31:0] out_ori_z,
  output logic               out_zero_norm,
  output logic               out_pos_saturated,

  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // Total depth: front stages, square root, divider and the final register.
  // The position results wait for the orientation in a delay line.
  localparam int LAT     = NORM_FRONT_STAGES + SQRT_STAGES + (QUAT_FRAC_BITS + 1) + 1;
  localparam int POS_DLY = LAT - POS_STAGES;

  // Register values after reset: identity rotation, zero center and shift.
  localparam pose_cfg_t CFG_RESET = '{
    rot:    '{w: 32'(64'd1 << QUAT_FRAC_BITS), default: '0},
    center: '0,
    shift:  '0
  };

  // Configuration registers, read directly at whatever stage needs them. The
  // user must change them only while no beat is in flight; it is not enforced.
  pose_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROT_W_X: begin
          cfg_r.rot.w <= cfg_data[31:0];
          cfg_r.rot.x <= cfg_data[63:32];
        end
        REG_ROT_Y_Z: begin
          cfg_r.rot.y <= cfg_data[31:0];
          cfg_r.rot.z <= cfg_data[63:32];
        end
        REG_CENTER_X: cfg_r.center.x <= cfg_data[31:0];
        REG_CENTER_Y: cfg_r.center.y <= cfg_data[31:0];
        REG_CENTER_Z: cfg_r.center.z <= cfg_data[31:0];
        REG_SHIFT_X:  cfg_r.shift.x  <= cfg_data[31:0];
        REG_SHIFT_Y:  cfg_r.shift.y  <= cfg_data[31:0];
        REG_SHIFT_Z:  cfg_r.shift.z  <= cfg_data[31:0];
      endcase
    end
  end

  // Pipeline control. Valid bits ride in a shift register next to the data;
  // every stage moves whenever the output stage is empty or being taken.
  logic [LAT-1:0] vld_r;
  logic           en;

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // The two datapaths.
  vec3_t pos_in;
  quat_t ori_in;
  vec3_t pos_res;
  logic  pos_sat;
  quat_t ori_res;
  logic  zero_norm;

  assign pos_in = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
  assign ori_in = '{w: in_ori_w, x: in_ori_x, y: in_ori_y, z: in_ori_z};

  rpt_pos_path #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_pos_path (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg_r),
    .pos     (pos_in),
    .pos_out (pos_res),
    .sat     (pos_sat)
  );

  rpt_quat_path #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_quat_path (
    .clk       (clk),
    .en        (en),
    .rot       (cfg_r.rot),
    .ori       (ori_in),
    .ori_out   (ori_res),
    .zero_norm (zero_norm)
  );

  // The position result is ready long before the orientation; this delay
  // line lines the two up so they leave in the same beat.
  vec3_t posd_r [POS_DLY];
  logic  satd_r [POS_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      posd_r[0] <= pos_res;
      satd_r[0] <= pos_sat;
      for (int s = 1; s < POS_DLY; s++) begin
        posd_r[s] <= posd_r[s-1];
        satd_r[s] <= satd_r[s-1];
      end
    end
  end

  assign out_valid         = vld_r[LAT-1];
  assign out_pos_x         = posd_r[POS_DLY-1].x;
  assign out_pos_y         = posd_r[POS_DLY-1].y;
  assign out_pos_z         = posd_r[POS_DLY-1].z;
  assign out_pos_saturated = satd_r[POS_DLY-1];
  assign out_ori_w         = ori_res.w;
  assign out_ori_x         = ori_res.x;
  assign out_ori_y         = ori_res.y;
  assign out_ori_z         = ori_res.z;
  assign out_zero_norm     = zero_norm;

  // A zero product is reported with an all-zero orientation.
  a_zero_norm_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |->
      out_ori_w == 0 && out_ori_x == 0 && out_ori_y == 0 && out_ori_z == 0)
    else $error("zero_norm beat carries a nonzero orientation");

  // A normalized orientation always keeps at least one nonzero component.
  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_norm |->
      out_ori_w != 0 || out_ori_x != 0 || out_ori_y != 0 || out_ori_z != 0)
    else $error("normalized orientation collapsed to zero");

  // While the pipeline holds, no beat moves or disappears.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits changed during a hold");

endmodule

>>> sv/rpt_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// floor(sqrt(rad)) of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module rpt_isqrt
  import rpt_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] n_r    [SQRT_STAGES];
  logic [33:0] rem_r  [SQRT_STAGES];
  logic [31:0] root_r [SQRT_STAGES];

  generate
    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_step
      logic [63:0] n_in;
      logic [33:0] rem_in;
      logic [31:0] root_in;
      logic [35:0] rem2;
      logic [35:0] trial;
      logic [63:0] n_nxt;
      logic [33:0] rem_nxt;
      logic [31:0] root_nxt;

      if (s == 0) begin : g_first
        assign n_in    = rad;
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign n_in    = n_r[s-1];
        assign rem_in  = rem_r[s-1];
        assign root_in = root_r[s-1];
      end

      always_comb begin
        rem2  = {rem_in, n_in[63:62]};
        trial = {2'b00, root_in, 2'b01};
        n_nxt = {n_in[61:0], 2'b00};
        if (rem2 >= trial) begin
          rem_nxt  = 34'(rem2 - trial);
          root_nxt = {root_in[30:0], 1'b1};
        end else begin
          rem_nxt  = rem2[33:0];
          root_nxt = {root_in[30:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          n_r[s]    <= n_nxt;
          rem_r[s]  <= rem_nxt;
          root_r[s] <= root_nxt;
        end
      end
    end
  endgenerate

  assign root = root_r[SQRT_STAGES-1];

endmodule

>>> sv/rpt_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned num / den with a QB-bit quotient, one quotient bit per stage.
// The upper part of num must be below den.
// ----------------------------------------------------------------------------
module rpt_div
  import rpt_pkg::*;
#(
  parameter int QB = QUAT_FRAC_BITS_DEF + 1,
  parameter int NW = QUAT_FRAC_BITS_DEF + 32
)
(
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic [QB-1:0] quo
);

  logic [31:0]   rem_r [QB];
  logic [QB-1:0] lo_r  [QB];
  logic [31:0]   den_r [QB];

  generate
    for (genvar s = 0; s < QB; s++) begin : g_step
      logic [31:0]   rem_in;
      logic [QB-1:0] lo_in;
      logic [31:0]   den_in;
      logic [32:0]   sh;
      logic [31:0]   rem_nxt;
      logic          qbit;

      if (s == 0) begin : g_first
        assign rem_in = 32'(num[NW-1:QB]);
        assign lo_in  = num[QB-1:0];
        assign den_in = den;
      end else begin : g_next
        assign rem_in = rem_r[s-1];
        assign lo_in  = lo_r[s-1];
        assign den_in = den_r[s-1];
      end

      always_comb begin
        sh = {rem_in, lo_in[QB-1]};
        if (sh >= {1'b0, den_in}) begin
          rem_nxt = 32'(sh - {1'b0, den_in});
          qbit    = 1'b1;
        end else begin
          rem_nxt = sh[31:0];
          qbit    = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          lo_r[s]  <= {lo_in[QB-2:0], qbit};
          den_r[s] <= den_in;
        end
      end
    end
  endgenerate

  assign quo = lo_r[QB-1];

endmodule

>>> sv/rpt_quat_path.sv
// ----------------------------------------------------------------------------
// Orientation datapath
// Hamilton product of the configured and input quaternions, block
// normalization, square root of the norm and per-component division.
// ----------------------------------------------------------------------------
module rpt_quat_path
  import rpt_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
)
(
  input  logic  clk,
  input  logic  en,
  input  quat_t rot,
  input  quat_t ori,
  output quat_t ori_out,
  output logic  zero_norm
);

  localparam int QB = QUAT_FRAC_BITS + 1;
  localparam int NW = QUAT_FRAC_BITS + 32;

  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } qside_t;

  logic signed [31:0] qv [4];
  logic signed [31:0] ov [4];

  assign qv[0] = rot.w;
  assign qv[1] = rot.x;
  assign qv[2] = rot.y;
  assign qv[3] = rot.z;
  assign ov[0] = ori.w;
  assign ov[1] = ori.x;
  assign ov[2] = ori.y;
  assign ov[3] = ori.z;

  // Stage 1: the sixteen cross products, exact.
  logic signed [63:0] prod_r [4][4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= 64'(qv[i]) * 64'(ov[j]);
        end
      end
    end
  end

  // Stage 2: product components with 2F fraction bits.
  logic signed [65:0] v_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= 66'(prod_r[0][0]) - 66'(prod_r[1][1]) - 66'(prod_r[2][2])
                - 66'(prod_r[3][3]);
      v_r[1] <= 66'(prod_r[0][1]) + 66'(prod_r[1][0]) + 66'(prod_r[2][3])
                - 66'(prod_r[3][2]);
      v_r[2] <= 66'(prod_r[0][2]) - 66'(prod_r[1][3]) + 66'(prod_r[2][0])
                + 66'(prod_r[3][1]);
      v_r[3] <= 66'(prod_r[0][3]) + 66'(prod_r[1][2]) - 66'(prod_r[2][1])
                + 66'(prod_r[3][0]);
    end
  end

  // Stage 3: sign and magnitude.
  logic [3:0][64:0] mag_r;
  logic [3:0]       neg3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg3_r[i] <= v_r[i][65];
        mag_r[i]  <= v_r[i][65] ? 65'(-v_r[i]) : 65'(v_r[i]);
      end
    end
  end

  // Stage 4: coarse normalization in steps of 16 bits.
  logic [3:0][79:0] ext;
  logic [79:0]      or4;
  logic [2:0]       chunk;
  logic [3:0][79:0] sh1_r;
  logic [3:0]       neg4_r;
  logic             zero4_r;

  always_comb begin
    or4   = '0;
    chunk = '0;
    for (int i = 0; i < 4; i++) begin
      ext[i] = {mag_r[i], 15'b0};
      or4    = or4 | ext[i];
    end
    for (int k = 4; k >= 0; k--) begin
      if (or4[79 - 16*k -: 16] != '0) begin
        chunk = 3'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sh1_r[i] <= ext[i] << {chunk, 4'b0000};
      end
      neg4_r  <= neg3_r;
      zero4_r <= (or4 == '0);
    end
  end

  // Stage 5: fine normalization; the largest magnitude ends with its top bit at bit 30.
  logic [79:0]      or5;
  logic [3:0]       lz;
  logic [3:0][79:0] sh2;
  logic [3:0][30:0] u5_r;
  qside_t           side5_r;

  always_comb begin
    or5 = '0;
    lz  = '0;
    for (int i = 0; i < 4; i++) begin
      or5 = or5 | sh1_r[i];
    end
    for (int j = 0; j < 16; j++) begin
      if (or5[64 + j]) begin
        lz = 4'(15 - j);
      end
    end
    for (int i = 0; i < 4; i++) begin
      sh2[i] = sh1_r[i] << lz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        u5_r[i] <= sh2[i][79:49];
      end
      side5_r <= '{neg: neg4_r, zero: zero4_r};
    end
  end

  // Stage 6: squares. Stage 7: squared norm.
  logic [3:0][61:0] sq_r;
  logic [3:0][30:0] u6_r;
  qside_t           side6_r;
  logic [63:0]      norm2_r;
  logic [3:0][30:0] u7_r;
  qside_t           side7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= 62'(u5_r[i]) * 62'(u5_r[i]);
      end
      u6_r    <= u5_r;
      side6_r <= side5_r;
      norm2_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]) + 64'(sq_r[3]);
      u7_r    <= u6_r;
      side7_r <= side6_r;
    end
  end

  // Square root, with the components and flags kept alongside.
  logic [31:0]      root;
  logic [3:0][30:0] u_sq_r    [SQRT_STAGES];
  qside_t           side_sq_r [SQRT_STAGES];

  rpt_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (norm2_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      u_sq_r[0]    <= u7_r;
      side_sq_r[0] <= side7_r;
      for (int s = 1; s < SQRT_STAGES; s++) begin
        u_sq_r[s]    <= u_sq_r[s-1];
        side_sq_r[s] <= side_sq_r[s-1];
      end
    end
  end

  // Division of each component by the root, rounded to nearest.
  logic [NW-1:0] num [4];
  logic [QB-1:0] quo [4];
  qside_t        side_dv_r [QB];

  generate
    for (genvar i = 0; i < 4; i++) begin : g_div
      assign num[i] = (NW'(u_sq_r[SQRT_STAGES-1][i]) << QUAT_FRAC_BITS)
                      + NW'(root >> 1);

      rpt_div #(
        .QB (QB),
        .NW (NW)
      ) u_div (
        .clk (clk),
        .en  (en),
        .num (num[i]),
        .den (root),
        .quo (quo[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      side_dv_r[0] <= side_sq_r[SQRT_STAGES-1];
      for (int s = 1; s < QB; s++) begin
        side_dv_r[s] <= side_dv_r[s-1];
      end
    end
  end

  // Final stage: restore signs; a zero product reads as zero.
  logic [31:0] res [4];
  quat_t       ori_r;
  logic        zero_r;
  qside_t      side_f;

  assign side_f = side_dv_r[QB-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (side_f.zero) begin
        res[i] = '0;
      end else if (side_f.neg[i]) begin
        res[i] = 32'(0) - 32'(quo[i]);
      end else begin
        res[i] = 32'(quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ori_r.w <= res[0];
      ori_r.x <= res[1];
      ori_r.y <= res[2];
      ori_r.z <= res[3];
      zero_r  <= side_f.zero;
    end
  end

  assign ori_out   = ori_r;
  assign zero_norm = zero_r;

endmodule

>>> sv/rpt_pos_path.sv
// ----------------------------------------------------------------------------
// Position datapath
// Rotation matrix from the configured quaternion, p' = R(p - c) + c + t,
// with saturation to 32 bits.
// ----------------------------------------------------------------------------
module rpt_pos_path
  import rpt_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
)
(
  input  logic      clk,
  input  logic      en,
  input  pose_cfg_t cfg,
  input  vec3_t     pos,
  output vec3_t     pos_out,
  output logic      sat
);

  localparam int F   = QUAT_FRAC_BITS;
  localparam int RW  = 67 - F;
  localparam int RH  = (RW + 1) / 2;
  localparam int RHI = RW - RH;
  localparam int PPW = RH + 18;
  localparam int FW  = RW + 33;
  localparam int AW  = RW + 35;

  localparam logic signed [RW-1:0] ONE     = RW'(64'd1 << F);
  localparam logic signed [AW-1:0] POS_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] POS_MIN = AW'(-64'sd2147483648);

  function automatic logic signed [RW-1:0] mat_term(input logic signed [64:0] s);
    logic signed [65:0] t;
    t = 66'(s) + (66'(1) << (F - 2));
    return RW'(t >>> (F - 1));
  endfunction

  logic signed [31:0] c [3];
  logic signed [31:0] t [3];
  logic signed [31:0] p [3];

  assign c[0] = cfg.center.x;
  assign c[1] = cfg.center.y;
  assign c[2] = cfg.center.z;
  assign t[0] = cfg.shift.x;
  assign t[1] = cfg.shift.y;
  assign t[2] = cfg.shift.z;
  assign p[0] = pos.x;
  assign p[1] = pos.y;
  assign p[2] = pos.z;

  // Matrix pipeline: product registers, then matrix registers. It follows the
  // configuration on its own, settling before items reach the matrix multiply.
  logic signed [63:0] m_xx_r, m_yy_r, m_zz_r, m_xy_r, m_xz_r, m_yz_r;
  logic signed [63:0] m_wx_r, m_wy_r, m_wz_r;
  logic signed [RW-1:0] rm_r [3][3];

  always_ff @(posedge clk) begin
    m_xx_r <= 64'(cfg.rot.x) * 64'(cfg.rot.x);
    m_yy_r <= 64'(cfg.rot.y) * 64'(cfg.rot.y);
    m_zz_r <= 64'(cfg.rot.z) * 64'(cfg.rot.z);
    m_xy_r <= 64'(cfg.rot.x) * 64'(cfg.rot.y);
    m_xz_r <= 64'(cfg.rot.x) * 64'(cfg.rot.z);
    m_yz_r <= 64'(cfg.rot.y) * 64'(cfg.rot.z);
    m_wx_r <= 64'(cfg.rot.w) * 64'(cfg.rot.x);
    m_wy_r <= 64'(cfg.rot.w) * 64'(cfg.rot.y);
    m_wz_r <= 64'(cfg.rot.w) * 64'(cfg.rot.z);
  end

  always_ff @(posedge clk) begin
    rm_r[0][0] <= ONE - mat_term(65'(m_yy_r) + 65'(m_zz_r));
    rm_r[0][1] <= mat_term(65'(m_xy_r) - 65'(m_wz_r));
    rm_r[0][2] <= mat_term(65'(m_xz_r) + 65'(m_wy_r));
    rm_r[1][0] <= mat_term(65'(m_xy_r) + 65'(m_wz_r));
    rm_r[1][1] <= ONE - mat_term(65'(m_xx_r) + 65'(m_zz_r));
    rm_r[1][2] <= mat_term(65'(m_yz_r) - 65'(m_wx_r));
    rm_r[2][0] <= mat_term(65'(m_xz_r) - 65'(m_wy_r));
    rm_r[2][1] <= mat_term(65'(m_yz_r) + 65'(m_wx_r));
    rm_r[2][2] <= ONE - mat_term(65'(m_xx_r) + 65'(m_yy_r));
  end

  // Stages 1 and 2: offset from the center, then a hold for the matrix.
  logic signed [32:0] d1_r [3];
  logic signed [32:0] d2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        d1_r[j] <= 33'(p[j]) - 33'(c[j]);
        d2_r[j] <= d1_r[j];
      end
    end
  end

  // Stage 3: each matrix product split into four narrow partial products.
  logic signed [PPW-1:0] pll_nxt [3][3];
  logic signed [PPW-1:0] plh_nxt [3][3];
  logic signed [PPW-1:0] phl_nxt [3][3];
  logic signed [PPW-1:0] phh_nxt [3][3];
  logic signed [PPW-1:0] pll_r   [3][3];
  logic signed [PPW-1:0] plh_r   [3][3];
  logic signed [PPW-1:0] phl_r   [3][3];
  logic signed [PPW-1:0] phh_r   [3][3];

  always_comb begin
    logic signed [RH:0]    rl;
    logic signed [RHI-1:0] rh;
    logic signed [16:0]    dl;
    logic signed [16:0]    dh;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rl = $signed({1'b0, rm_r[i][j][RH-1:0]});
        rh = $signed(rm_r[i][j][RW-1:RH]);
        dl = $signed({1'b0, d2_r[j][15:0]});
        dh = $signed(d2_r[j][32:16]);
        pll_nxt[i][j] = PPW'(rl) * PPW'(dl);
        plh_nxt[i][j] = PPW'(rl) * PPW'(dh);
        phl_nxt[i][j] = PPW'(rh) * PPW'(dl);
        phh_nxt[i][j] = PPW'(rh) * PPW'(dh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= pll_nxt;
      plh_r <= plh_nxt;
      phl_r <= phl_nxt;
      phh_r <= phh_nxt;
    end
  end

  // Stage 4: full products. Stage 5: row sums plus the rounding half.
  logic signed [FW-1:0] pr_r  [3][3];
  logic signed [AW-1:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[i][j] <= (FW'(phh_r[i][j]) <<< (RH + 16)) + (FW'(phl_r[i][j]) <<< RH)
                        + (FW'(plh_r[i][j]) <<< 16) + FW'(pll_r[i][j]);
        end
        acc_r[i] <= AW'(pr_r[i][0]) + AW'(pr_r[i][1]) + AW'(pr_r[i][2])
                    + (AW'(1) << (F - 1));
      end
    end
  end

  // Stage 6: drop the fraction, add center and translation, saturate.
  logic signed [AW-1:0] y [3];
  logic signed [31:0]   res [3];
  logic [2:0]           clip;
  logic signed [31:0]   out_r [3];
  logic                 sat_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y[i] = AW'(acc_r[i] >>> F) + AW'(33'(c[i]) + 33'(t[i]));
      if (y[i] > POS_MAX) begin
        res[i]  = POS_MAX[31:0];
        clip[i] = 1'b1;
      end else if (y[i] < POS_MIN) begin
        res[i]  = POS_MIN[31:0];
        clip[i] = 1'b1;
      end else begin
        res[i]  = y[i][31:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res;
      sat_r <= |clip;
    end
  end

  assign pos_out.x = out_r[0];
  assign pos_out.y = out_r[1];
  assign pos_out.z = out_r[2];
  assign sat       = sat_r;

endmodule

>>> tb/rpt_checker.sv
// ----------------------------------------------------------------------------
// Rigid pose transform checker
// Watches the input, output and register write ports of the block, predicts
// every output beat from the accepted input beat and the register values in
// force at that time, and compares the output beats field by field in order.
// ----------------------------------------------------------------------------
module rpt_checker
  import rpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_ori_w,
  input  logic signed [31:0] in_ori_x,
  input  logic signed [31:0] in_ori_y,
  input  logic signed [31:0] in_ori_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic signed [31:0] out_pos_z,
  input  logic signed [31:0] out_ori_w,
  input  logic signed [31:0] out_ori_x,
  input  logic signed [31:0] out_ori_y,
  input  logic signed [31:0] out_ori_z,
  input  logic               out_zero_norm,
  input  logic               out_pos_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_poses
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QF = 30;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] ori [4];
    logic               zero_norm;
    logic               pos_sat;
  } pose_out_t;

  pose_out_t moved_poses [$];

  // Shadow copy of the registers.
  logic signed [31:0] rq_w, rq_x, rq_y, rq_z;
  logic signed [31:0] ctr [3];
  logic signed [31:0] sft [3];

  assign pending_poses = moved_poses.size();

  function automatic logic signed [127:0] rnd(logic signed [127:0] a, int s);
    logic signed [127:0] b;
    b = a + (128'sd1 <<< (s - 1));
    return b >>> s;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic pose_out_t move_pose(logic signed [31:0] p [3],
                                          logic signed [31:0] o [4]);
    pose_out_t r;
    logic signed [127:0] qw, qx, qy, qz, one, acc, lim_hi, lim_lo;
    logic signed [127:0] m [3][3];
    logic signed [127:0] d [3];
    logic signed [127:0] ov [4];
    logic signed [127:0] v [4];
    logic [127:0] mag [4];
    logic [127:0] mx;
    logic [63:0] u [4];
    logic [63:0] norm2, rt, qq;
    int len;
    qw = rq_w; qx = rq_x; qy = rq_y; qz = rq_z;
    one = 128'sd1 <<< QF;
    lim_hi = 128'sd2147483647;
    lim_lo = -128'sd2147483648;
    m[0][0] = one - rnd(qy*qy + qz*qz, QF - 1);
    m[0][1] = rnd(qx*qy - qw*qz, QF - 1);
    m[0][2] = rnd(qx*qz + qw*qy, QF - 1);
    m[1][0] = rnd(qx*qy + qw*qz, QF - 1);
    m[1][1] = one - rnd(qx*qx + qz*qz, QF - 1);
    m[1][2] = rnd(qy*qz - qw*qx, QF - 1);
    m[2][0] = rnd(qx*qz - qw*qy, QF - 1);
    m[2][1] = rnd(qy*qz + qw*qx, QF - 1);
    m[2][2] = one - rnd(qx*qx + qy*qy, QF - 1);
    for (int i = 0; i < 3; i++) d[i] = 128'(p[i]) - 128'(ctr[i]);
    r.pos_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0]*d[0] + m[i][1]*d[1] + m[i][2]*d[2];
      acc = rnd(acc, QF) + 128'(ctr[i]) + 128'(sft[i]);
      if (acc > lim_hi) begin
        r.pos[i] = 32'sh7fffffff; r.pos_sat = 1'b1;
      end else if (acc < lim_lo) begin
        r.pos[i] = 32'sh80000000; r.pos_sat = 1'b1;
      end else begin
        r.pos[i] = acc[31:0];
      end
    end
    for (int i = 0; i < 4; i++) ov[i] = o[i];
    // Hamilton product of the configured rotation and the object orientation.
    v[0] = qw*ov[0] - qx*ov[1] - qy*ov[2] - qz*ov[3];
    v[1] = qw*ov[1] + qx*ov[0] + qy*ov[3] - qz*ov[2];
    v[2] = qw*ov[2] - qx*ov[3] + qy*ov[0] + qz*ov[1];
    v[3] = qw*ov[3] + qx*ov[2] - qy*ov[1] + qz*ov[0];
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 4; i++) r.ori[i] = '0;
      r.zero_norm = 1'b1;
    end else begin
      len = 0;
      for (int b = 0; b < 128; b++) if (mx[b]) len = b + 1;
      norm2 = 0;
      for (int i = 0; i < 4; i++) begin
        // Scale all four by one power of two so the largest has 31 bits.
        u[i] = len > 31 ? 64'(mag[i] >> (len - 31)) : 64'(mag[i] << (31 - len));
        norm2 += u[i] * u[i];
      end
      rt = isqrt(norm2);
      for (int i = 0; i < 4; i++) begin
        qq = ((u[i] << QF) + (rt >> 1)) / rt;
        r.ori[i] = v[i] < 0 ? 32'(-qq) : qq[31:0];
      end
      r.zero_norm = 1'b0;
    end
    return r;
  endfunction

  task automatic cmp(string nm, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", nm, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic signed [31:0] p [3];
    logic signed [31:0] o [4];
    pose_out_t e;
    if (!rst_n) begin
      rq_w <= 32'sd1 <<< QF; rq_x <= '0; rq_y <= '0; rq_z <= '0;
      for (int i = 0; i < 3; i++) begin
        ctr[i] <= '0; sft[i] <= '0;
      end
      fail_count = 0;
    end else begin
      // Prediction uses the registers as they stand before this edge.
      if (in_valid && !in_stall) begin
        p = '{in_pos_x, in_pos_y, in_pos_z};
        o = '{in_ori_w, in_ori_x, in_ori_y, in_ori_z};
        moved_poses.push_back(move_pose(p, o));
      end
      if (out_valid && !out_stall) begin
        if (moved_poses.size() == 0) begin
          $error("output beat with no pose pending");
          fail_count++;
        end else begin
          e = moved_poses.pop_front();
          cmp("out_pos_x", e.pos[0], out_pos_x);
          cmp("out_pos_y", e.pos[1], out_pos_y);
          cmp("out_pos_z", e.pos[2], out_pos_z);
          cmp("out_ori_w", e.ori[0], out_ori_w);
          cmp("out_ori_x", e.ori[1], out_ori_x);
          cmp("out_ori_y", e.ori[2], out_ori_y);
          cmp("out_ori_z", e.ori[3], out_ori_z);
          cmp("out_zero_norm", 32'(e.zero_norm), 32'(out_zero_norm));
          cmp("out_pos_saturated", 32'(e.pos_sat), 32'(out_pos_saturated));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROT_W_X: begin
            rq_w <= cfg_data[31:0]; rq_x <= cfg_data[63:32];
          end
          REG_ROT_Y_Z: begin
            rq_y <= cfg_data[31:0]; rq_z <= cfg_data[63:32];
          end
          REG_CENTER_X: ctr[0] <= cfg_data[31:0];
          REG_CENTER_Y: ctr[1] <= cfg_data[31:0];
          REG_CENTER_Z: ctr[2] <= cfg_data[31:0];
          REG_SHIFT_X:  sft[0] <= cfg_data[31:0];
          REG_SHIFT_Y:  sft[1] <= cfg_data[31:0];
          REG_SHIFT_Z:  sft[2] <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end
endmodule

>>> tb/tb_rigid_pose_transform.sv
// ----------------------------------------------------------------------------
// Rigid pose transform testbench
// Streams object poses through the block under several register settings,
// with random gaps on the input side and random stalls on the output side.
// A separate checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_rigid_pose_transform;
  import rpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth at the default fraction width.
  localparam int DEPTH = 71;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [31:0] Q_ONE = 32'h4000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_ori_w = '0, in_ori_x = '0, in_ori_y = '0, in_ori_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_ori_w, out_ori_x, out_ori_y, out_ori_z;
  logic out_zero_norm, out_pos_saturated;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int fail_count;
  int pending_poses;
  int idle_cycles = 0;
  // When set, neither side idles.
  logic busy_stretch = 1'b0;

  always #4 clk = ~clk;

  rigid_pose_transform dut (.*);

  rpt_checker u_checker (.*);

  // The output side stalls at random, with odds of 31 in 100, except in a stretch.
  always @(posedge clk) begin
    out_stall <= !busy_stretch && ($urandom_range(99) < 31);
  end

  // The watchdog counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  // A mostly unit quaternion component: near +-1.0, near zero, or any word.
  function automatic logic [31:0] rand_quat();
    case ($urandom_range(4))
      0: return Q_ONE - $urandom_range(1 << 20);
      1: return -(Q_ONE - $urandom_range(1 << 20));
      2: return $urandom_range(1 << 29) - (1 << 28);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pose(logic [31:0] px, py, pz, ow, ox, oy, oz);
    while (!busy_stretch && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_ori_w <= ow; in_ori_x <= ox; in_ori_y <= oy; in_ori_z <= oz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers are only written with the pipeline drained.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_poses != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_all(logic [63:0] wx, yz, logic [31:0] c [3], s [3]);
    write_reg(REG_ROT_W_X, wx);
    write_reg(REG_ROT_Y_Z, yz);
    write_reg(REG_CENTER_X, {32'b0, c[0]});
    write_reg(REG_CENTER_Y, {32'b0, c[1]});
    write_reg(REG_CENTER_Z, {32'b0, c[2]});
    write_reg(REG_SHIFT_X, {32'b0, s[0]});
    write_reg(REG_SHIFT_Y, {32'b0, s[1]});
    write_reg(REG_SHIFT_Z, {32'b0, s[2]});
  endtask

  task automatic random_poses(int n);
    for (int i = 0; i < n; i++) begin
      send_pose(rand_word(), rand_word(), rand_word(),
                rand_quat(), rand_quat(), rand_quat(), rand_quat());
    end
  endtask

  initial begin
    logic [31:0] c [3];
    logic [31:0] s [3];
    logic [63:0] wx, yz;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed poses at the reset setting: identity rotation.
    send_pose(0, 0, 0, Q_ONE, 0, 0, 0);
    send_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, Q_ONE, 0, 0);
    send_pose(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
    send_pose(32'h12345678, 32'hfedcba98, 1, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000);
    send_pose(-1, 1, -1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_pose(5, 6, 7, 0, 0, 0, 1);
    drain();

    // Half-turn about z with a large shift, so positions overflow.
    c = '{32'h0001_0000, 32'hffff_0000, 0};
    s = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    write_all({32'h0, 32'h0}, {Q_ONE, 32'h0}, c, s);
    send_pose(32'h7fffffff, 32'h7fffffff, 32'h80000000, Q_ONE, 0, 0, 0);
    send_pose(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, Q_ONE, 0);
    send_pose(0, 0, 0, 0, 0, 0, -Q_ONE);
    // Conjugate orientation gives a zero-norm product only if q is zero;
    // a zero quaternion input does it here.
    send_pose(1, 2, 3, 0, 0, 0, 0);
    drain();

    // Extreme, non-unit rotation quaternion with extreme center and shift.
    c = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    s = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    write_all(64'h8000_0000_7fff_ffff, 64'h7fff_ffff_8000_0000, c, s);
    send_pose(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff);
    send_pose(0, 0, 0, 1, 0, 0, 0);
    send_pose(-5, 5, -5, 32'h80000000, 0, 0, 0);
    drain();

    // Zero rotation quaternion: every product is zero.
    c = '{0, 0, 0};
    s = '{32'h0000_8000, 0, 32'hffff_8000};
    write_all(64'h0, 64'h0, c, s);
    send_pose(32'h00010000, 32'h00020000, 32'h00030000, Q_ONE, Q_ONE, 0, 0);
    send_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    drain();

    // Random phases with fresh settings; the first runs without any idling.
    for (int ph = 0; ph < 6; ph++) begin
      busy_stretch <= (ph == 0);
      wx = {rand_quat(), rand_quat()};
      yz = {rand_quat(), rand_quat()};
      for (int k = 0; k < 3; k++) begin
        c[k] = rand_word();
        s[k] = $urandom_range(3) == 0 ? rand_word() : $urandom_range(1 << 20);
      end
      write_all(wx, yz, c, s);
      random_poses(210);
      drain();
    end
    busy_stretch <= 1'b0;

    repeat (DEPTH + 20) @(posedge clk);
    if (fail_count == 0 && pending_poses == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_poses != 0) $error("%0d poses never came out", pending_poses);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/rpt_pkg.sv
sv/rpt_isqrt.sv
sv/rpt_div.sv
sv/rpt_quat_path.sv
sv/rpt_pos_path.sv
sv/rigid_pose_transform.sv
tb/rpt_checker.sv
tb/tb_rigid_pose_transform.sv
